// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers sampled on clk_i and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising edge of clk_i outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, cond, cons, msg) \
  `ASSERT_CLK(label, (cond) |-> (cons), msg)

`endif

// ----- hdl/atfe_pkg.sv -----
// ---------------------------------------------------------------------------
// atfe_pkg
// Shared types and codes of the terminal frame encoder.
// ---------------------------------------------------------------------------
package atfe_pkg;

  localparam logic [1:0] ActBegin = 2'd0;
  localparam logic [1:0] ActCell  = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [20:0] glyph;
    logic        is_continuation;
    logic [4:0]  fg_color;
    logic        bold;
    logic        dim;
    logic        underline;
    logic        inverse;
    logic        caret_present;
    logic [11:0] caret_x;
    logic [11:0] caret_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic        begin_f;
    logic        rst_f;
    logic        cur_f;
    logic        sty_f;
    logic        chr_f;
    logic        show_f;
    logic [12:0] row;
    logic [12:0] col;
    logic [8:0]  style;
    logic [20:0] cp;
    logic [1:0]  len;
  } job_t;

endpackage

// ----- hdl/atfe_front.sv -----
// ---------------------------------------------------------------------------
// atfe_front
// Accepts requests, tracks frame position and style, and issues byte jobs.
// ---------------------------------------------------------------------------
module atfe_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  atfe_pkg::in_item_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output atfe_pkg::job_t     job_o
);

  localparam int         CapInt = (MAX_DIM < 9999) ? MAX_DIM : 9999;
  localparam logic [13:0] Cap   = 14'(CapInt);

  logic [12:0] width_q, height_q, col_q, col_d, row_q, row_d;
  logic [8:0]  style_q, style_d;
  logic [12:0] w, h, col_inc;
  logic [4:0]  fg_eff;
  logic [8:0]  st;
  logic [20:0] cpe;
  logic        accept, push, caret;

  assign w = ({1'b0, width_q} > Cap) ? Cap[12:0] : width_q;
  assign h = ({1'b0, height_q} > Cap) ? Cap[12:0] : height_q;
  assign accept = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o = accept && push;
  assign col_inc = col_q + 13'd1;

  always_comb begin
    fg_eff = (in_data_i.fg_color > 5'd16) ? 5'd0 : in_data_i.fg_color;
    st = {in_data_i.inverse, in_data_i.underline, in_data_i.dim, in_data_i.bold, fg_eff};
    if (in_data_i.glyph > 21'h10FFFF ||
        (in_data_i.glyph >= 21'h00D800 && in_data_i.glyph <= 21'h00DFFF)) begin
      cpe = 21'h00FFFD;
    end else begin
      cpe = in_data_i.glyph;
    end
  end

  always_comb begin
    job_o = '0;
    push = 1'b0;
    caret = 1'b0;
    col_d = col_q;
    row_d = row_q;
    style_d = style_q;
    job_o.cp = cpe;
    if (cpe < 21'h80) begin
      job_o.len = 2'd0;
    end else if (cpe < 21'h800) begin
      job_o.len = 2'd1;
    end else if (cpe < 21'h10000) begin
      job_o.len = 2'd2;
    end else begin
      job_o.len = 2'd3;
    end
    unique case (in_data_i.action)
      atfe_pkg::ActBegin: begin
        job_o.begin_f = 1'b1;
        push = 1'b1;
        col_d = '0;
        row_d = '0;
        style_d = '0;
      end
      atfe_pkg::ActCell: begin
        if (w != 13'd0 && row_q < h) begin
          job_o.cur_f = (col_q == 13'd0);
          job_o.row = row_q + 13'd1;
          job_o.col = 13'd1;
          if (!in_data_i.is_continuation) begin
            job_o.sty_f = (st != style_q);
            job_o.style = st;
            job_o.chr_f = 1'b1;
            style_d = st;
          end
          push = job_o.cur_f || job_o.chr_f;
          if (col_inc >= w) begin
            col_d = '0;
            row_d = row_q + 13'd1;
          end else begin
            col_d = col_inc;
          end
        end
      end
      atfe_pkg::ActEnd: begin
        caret = in_data_i.caret_present && ({1'b0, in_data_i.caret_x} < w) &&
                ({1'b0, in_data_i.caret_y} < h);
        job_o.rst_f = (style_q != 9'd0);
        job_o.cur_f = caret;
        job_o.show_f = caret;
        job_o.row = {1'b0, in_data_i.caret_y} + 13'd1;
        job_o.col = {1'b0, in_data_i.caret_x} + 13'd1;
        style_d = '0;
        push = job_o.rst_f || caret;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd80;
      height_q <= 13'd24;
      col_q <= '0;
      row_q <= '0;
      style_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == atfe_pkg::CfgWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == atfe_pkg::CfgHeight) begin
        height_q <= cfg_data_i;
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        style_q <= style_d;
      end
    end
  end

endmodule

// ----- hdl/atfe_fifo.sv -----
// ---------------------------------------------------------------------------
// atfe_fifo
// Two-entry job queue between the front and the byte sequencer.
// ---------------------------------------------------------------------------
module atfe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  atfe_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output atfe_pkg::job_t data_o,
  output logic           empty_o
);

  atfe_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- hdl/atfe_back.sv -----
// ---------------------------------------------------------------------------
// atfe_back
// Byte sequencer: expands one job into escape sequences and UTF-8 bytes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  atfe_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atfe_pkg::out_item_t out_data_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BEGIN = 4'd1;
  localparam logic [3:0] S_RST   = 4'd2;
  localparam logic [3:0] S_CHEAD = 4'd3;
  localparam logic [3:0] S_CONV  = 4'd4;
  localparam logic [3:0] S_DIG   = 4'd5;
  localparam logic [3:0] S_SEMI  = 4'd6;
  localparam logic [3:0] S_CEND  = 4'd7;
  localparam logic [3:0] S_STY   = 4'd8;
  localparam logic [3:0] S_UTF   = 4'd9;
  localparam logic [3:0] S_SHOW  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [2:0] K_BEGIN = 3'd0;
  localparam logic [2:0] K_RST   = 3'd1;
  localparam logic [2:0] K_CUR   = 3'd2;
  localparam logic [2:0] K_STY   = 3'd3;
  localparam logic [2:0] K_UTF   = 3'd4;
  localparam logic [2:0] K_SHOW  = 3'd5;

  localparam logic [7:0] Esc = 8'h1B;

  function automatic logic [3:0] first_seg(atfe_pkg::job_t j, logic [2:0] k);
    logic [3:0] s;
    if (k == K_BEGIN && j.begin_f) begin
      s = S_BEGIN;
    end else if (k <= K_RST && j.rst_f) begin
      s = S_RST;
    end else if (k <= K_CUR && j.cur_f) begin
      s = S_CHEAD;
    end else if (k <= K_STY && j.sty_f) begin
      s = S_STY;
    end else if (k <= K_UTF && j.chr_f) begin
      s = S_UTF;
    end else if (k <= K_SHOW && j.show_f) begin
      s = S_SHOW;
    end else begin
      s = S_DONE;
    end
    return s;
  endfunction

  function automatic logic [7:0] begin_byte(logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0, 4'd6, 4'd10: b = Esc;
      4'd1, 4'd7, 4'd11: b = "[";
      4'd2:  b = "?";
      4'd3:  b = "2";
      4'd4:  b = "5";
      4'd5:  b = "l";
      4'd8:  b = "0";
      4'd9:  b = "m";
      4'd12: b = "2";
      default: b = "J";
    endcase
    return b;
  endfunction

  function automatic logic [7:0] show_byte(logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0: b = Esc;
      3'd1: b = "[";
      3'd2: b = "?";
      3'd3: b = "2";
      3'd4: b = "5";
      default: b = "h";
    endcase
    return b;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len, logic [1:0] i);
    logic [7:0] b;
    if (i == 2'd0) begin
      case (len)
        2'd0: b = {1'b0, cp[6:0]};
        2'd1: b = {3'b110, cp[10:6]};
        2'd2: b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (len - i)
        2'd0: b = {2'b10, cp[5:0]};
        2'd1: b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

  logic [3:0]  st_q, st_d, idx_q, idx_d;
  atfe_pkg::job_t job_q, job_d;
  logic [12:0] bin_q, bin_d;
  logic [15:0] bcd_q, bcd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        which_q, which_d, started_q, started_d;
  logic        pend_v_q;
  logic [7:0]  pend_q;
  logic        out_v_q;
  atfe_pkg::out_item_t out_q;
  logic        gen_v, out_room, can, adv;
  logic [7:0]  gen_b;
  logic [3:0]  dig;
  logic [4:0]  fm1;
  logic [15:0] bcd_adj;

  assign out_room = !out_v_q || !out_stall_i;
  assign can = !pend_v_q || out_room;
  assign adv = !gen_v || can;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign pop_o = (st_q == S_IDLE) && !empty_i;
  assign fm1 = job_q.style[4:0] - 5'd1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
    case (idx_q[1:0])
      2'd0: dig = bcd_q[15:12];
      2'd1: dig = bcd_q[11:8];
      2'd2: dig = bcd_q[7:4];
      default: dig = bcd_q[3:0];
    endcase
  end

  always_comb begin
    gen_v = 1'b0;
    gen_b = '0;
    st_d = st_q;
    idx_d = idx_q + 4'd1;
    job_d = job_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    which_d = which_q;
    started_d = started_q;
    unique case (st_q)
      S_IDLE: begin
        idx_d = '0;
        if (!empty_i) begin
          job_d = job_i;
          st_d = first_seg(job_i, K_BEGIN);
        end
      end
      S_BEGIN: begin
        gen_v = 1'b1;
        gen_b = begin_byte(idx_q);
        if (idx_q == 4'd13) begin
          idx_d = '0;
          st_d = first_seg(job_q, K_RST);
        end
      end
      S_RST: begin
        gen_v = 1'b1;
        gen_b = begin_byte(idx_q + 4'd6);
        if (idx_q == 4'd3) begin
          idx_d = '0;
          st_d = first_seg(job_q, K_CUR);
        end
      end
      S_CHEAD: begin
        gen_v = 1'b1;
        gen_b = (idx_q == 4'd0) ? Esc : "[";
        if (idx_q == 4'd1) begin
          bin_d = job_q.row;
          bcd_d = '0;
          cnt_d = 4'd13;
          which_d = 1'b0;
          st_d = S_CONV;
        end
      end
      S_CONV: begin
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        cnt_d = cnt_q - 4'd1;
        idx_d = '0;
        started_d = 1'b0;
        if (cnt_q == 4'd1) begin
          st_d = S_DIG;
        end
      end
      S_DIG: begin
        gen_v = (dig != 4'd0) || started_q || (idx_q[1:0] == 2'd3);
        gen_b = {4'h3, dig};
        started_d = started_q || gen_v;
        if (idx_q[1:0] == 2'd3) begin
          st_d = which_q ? S_CEND : S_SEMI;
        end
      end
      S_SEMI: begin
        gen_v = 1'b1;
        gen_b = ";";
        bin_d = job_q.col;
        bcd_d = '0;
        cnt_d = 4'd13;
        which_d = 1'b1;
        st_d = S_CONV;
      end
      S_CEND: begin
        gen_v = 1'b1;
        gen_b = "H";
        idx_d = '0;
        st_d = first_seg(job_q, K_STY);
      end
      S_STY: begin
        case (idx_q)
          4'd0: begin gen_v = 1'b1; gen_b = Esc; end
          4'd1: begin gen_v = 1'b1; gen_b = "["; end
          4'd2: begin gen_v = 1'b1; gen_b = "0"; end
          4'd3: begin gen_v = (job_q.style[4:0] != 5'd0); gen_b = ";"; end
          4'd4: begin
            gen_v = (job_q.style[4:0] != 5'd0);
            gen_b = (job_q.style[4:0] <= 5'd8) ? "3" : "9";
          end
          4'd5: begin gen_v = (job_q.style[4:0] != 5'd0); gen_b = {5'b00110, fm1[2:0]}; end
          4'd6: begin gen_v = job_q.style[5]; gen_b = ";"; end
          4'd7: begin gen_v = job_q.style[5]; gen_b = "1"; end
          4'd8: begin gen_v = job_q.style[6]; gen_b = ";"; end
          4'd9: begin gen_v = job_q.style[6]; gen_b = "2"; end
          4'd10: begin gen_v = job_q.style[7]; gen_b = ";"; end
          4'd11: begin gen_v = job_q.style[7]; gen_b = "4"; end
          4'd12: begin gen_v = job_q.style[8]; gen_b = ";"; end
          4'd13: begin gen_v = job_q.style[8]; gen_b = "7"; end
          default: begin gen_v = 1'b1; gen_b = "m"; end
        endcase
        if (idx_q == 4'd14) begin
          idx_d = '0;
          st_d = first_seg(job_q, K_UTF);
        end
      end
      S_UTF: begin
        gen_v = 1'b1;
        gen_b = utf8_byte(job_q.cp, job_q.len, idx_q[1:0]);
        if (idx_q[1:0] == job_q.len) begin
          idx_d = '0;
          st_d = first_seg(job_q, K_SHOW);
        end
      end
      S_SHOW: begin
        gen_v = 1'b1;
        gen_b = show_byte(idx_q[2:0]);
        if (idx_q == 4'd5) begin
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        idx_d = '0;
        if (out_room) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      idx_q <= '0;
      cnt_q <= '0;
      which_q <= 1'b0;
      started_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        st_q <= st_d;
        idx_q <= idx_d;
        cnt_q <= cnt_d;
        which_q <= which_d;
        started_q <= started_d;
      end
      if (gen_v && can) begin
        pend_v_q <= 1'b1;
      end else if (st_q == S_DONE && out_room) begin
        pend_v_q <= 1'b0;
      end
      if ((gen_v && can && pend_v_q) || (st_q == S_DONE && out_room)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      job_q <= job_d;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
    if (gen_v && can) begin
      pend_q <= gen_b;
      if (pend_v_q) begin
        out_q <= '{out_byte: pend_q, last_byte: 1'b0};
      end
    end else if (st_q == S_DONE && out_room) begin
      out_q <= '{out_byte: pend_q, last_byte: 1'b1};
    end
  end

  `ASSERT_IMPL(done_has_pending, st_q == S_DONE, pend_v_q, "job finished with no byte held")
  `ASSERT_IMPL(idle_no_pending, st_q == S_IDLE, !pend_v_q, "byte held while idle")
  `ASSERT_IMPL(utf_index_range, st_q == S_UTF, idx_q[1:0] <= job_q.len, "UTF-8 index overrun")
  `ASSERT_CLK(conv_to_digits, (st_q == S_CONV && cnt_q == 4'd1) |=> (st_q == S_DIG),
              "conversion did not hand over to digits")

endmodule

// ----- hdl/ansi_terminal_frame_encoder.sv -----
// ---------------------------------------------------------------------------
// ansi_terminal_frame_encoder
// Turns begin, cell and end requests into a VT100/ANSI terminal byte stream.
// ---------------------------------------------------------------------------
// One output byte leaves per cycle while the sequencer emits bytes and the
// output is not stalled. Besides its bytes, each job passes through a load
// step and a final hand-off step in the sequencer; every cursor position
// converts each decimal number with a bit-serial binary to BCD conversion
// and also walks over its suppressed leading zeros. The front keeps accepting
// requests until two jobs wait in the queue and stalls while both entries
// are taken.
module ansi_terminal_frame_encoder #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atfe_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atfe_pkg::out_item_t out_data_o
);

  atfe_pkg::job_t push_job, pop_job;
  logic push, pop, full, empty;

  atfe_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  atfe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pop_job),
    .empty_o(empty)
  );

  atfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
